>>> hw/rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the stripe chunk address mapper: field
// widths, striping geometry, status and request codes, control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    // striping geometry
    localparam int BLOCK_BYTES       = 4096;
    localparam int BLOCKS_PER_STRIPE = 4;
    localparam int MAX_SERVERS       = 16;
    localparam int MAX_CHUNKS        = 32;

    localparam int BLK_LOG2  = $clog2(BLOCK_BYTES);
    localparam int UNIT_LOG2 = $clog2(BLOCK_BYTES * BLOCKS_PER_STRIPE);

    // field widths
    localparam int POS_W    = 40;
    localparam int LEN_W    = 17;
    localparam int WID_W    = 5;
    localparam int STAT_W   = 2;
    localparam int SRV_W    = 4;
    localparam int CHUNK_W  = BLK_LOG2 + 1;
    localparam int BOFF_W   = 17;
    localparam int STRIPE_W = POS_W - UNIT_LOG2;
    localparam int CNT_W    = $clog2(MAX_CHUNKS);

    // request kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_PAST_EOF  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_WIDTH = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic check;
        logic div_start;
        logic emit_status;
        logic emit_chunk;
    } scm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic reject;
        logic zero_len;
        logic div_done;
        logic out_free;
        logic chunk_last;
    } scm_sts_t;

endpackage : scm_pkg

`default_nettype wire

>>> hw/rtl/scm_div.sv
// ----------------------------------------------------------------------------
// scm_div
// Restoring divider, one quotient bit per cycle: splits the stripe number
// into stripe row (quotient) and server (remainder) by the stripe width.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [scm_pkg::STRIPE_W-1:0]  dividend,
    input  wire [scm_pkg::WID_W-1:0]     divisor,
    output logic                         done,
    output logic [scm_pkg::STRIPE_W-1:0] quotient,
    output logic [scm_pkg::SRV_W-1:0]    remainder
);
    import scm_pkg::*;

    localparam int DCNT_W = $clog2(STRIPE_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [WID_W-1:0]    rem_reg, rem_next;
    logic [STRIPE_W-1:0] quo_reg, quo_next;
    logic [WID_W-1:0]    divisor_reg, divisor_next;
    logic [WID_W-1:0]    trial;
    logic                fits;

    // one trial subtraction per cycle
    assign trial = {rem_reg[SRV_W-1:0], quo_reg[STRIPE_W-1]};
    assign fits  = (trial >= divisor_reg);

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = DCNT_W'(STRIPE_W - 1);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - divisor_reg) : trial;
            quo_next = {quo_reg[STRIPE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[SRV_W-1:0];

endmodule : scm_div

`default_nettype wire

>>> hw/rtl/scm_dpath.sv
// ----------------------------------------------------------------------------
// scm_dpath
// Datapath: request registers, end-of-file and width checks, read clamp,
// stripe divider, incremental chunk walker and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_dpath (
    input  wire                          aclk,
    input  wire                          aresetn,
    // control
    input  wire scm_pkg::scm_cmd_t       cmd,
    output scm_pkg::scm_sts_t            sts,
    // configuration
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [scm_pkg::WID_W-1:0]     cfg_data,
    // request fields
    input  wire                          s_op,
    input  wire [scm_pkg::POS_W-1:0]     s_start_offset,
    input  wire [scm_pkg::LEN_W-1:0]     s_request_bytes,
    input  wire [scm_pkg::POS_W-1:0]     s_file_size,
    input  wire [scm_pkg::WID_W-1:0]     s_stripe_width,
    // result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [scm_pkg::STAT_W-1:0]   m_status,
    output logic [scm_pkg::SRV_W-1:0]    m_server_id,
    output logic [scm_pkg::POS_W-1:0]    m_server_offset,
    output logic [scm_pkg::CHUNK_W-1:0]  m_chunk_bytes,
    output logic [scm_pkg::BOFF_W-1:0]   m_buffer_offset,
    output logic                         m_last
);
    import scm_pkg::*;

    logic [WID_W-1:0]    num_servers_reg;
    logic                m_valid_reg;

    logic                op_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [LEN_W-1:0]    bytes_reg;
    logic [POS_W-1:0]    fsize_reg;
    logic [WID_W-1:0]    width_reg;
    logic [STAT_W-1:0]   status_code_reg;
    logic [BOFF_W-1:0]   boff_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [STRIPE_W-1:0] q_reg;
    logic [SRV_W-1:0]    r_reg;

    logic [STAT_W-1:0]   out_status_reg;
    logic [SRV_W-1:0]    out_server_reg;
    logic [POS_W-1:0]    out_soff_reg;
    logic [CHUNK_W-1:0]  out_len_reg;
    logic [BOFF_W-1:0]   out_boff_reg;
    logic                out_last_reg;

    logic                past_end;
    logic                bad_width;
    logic [POS_W-1:0]    avail;
    logic                clamp_hit;
    logic [LEN_W-1:0]    bytes_clamp;

    logic [CHUNK_W-1:0]  room;
    logic [CHUNK_W-1:0]  len;
    logic                chunk_last;
    logic [POS_W-1:0]    pos_next;
    logic                unit_wrap;
    logic [WID_W-1:0]    r_inc;

    logic                div_done;
    logic [STRIPE_W-1:0] div_quo;
    logic [SRV_W-1:0]    div_rem;

    assign cfg_ready = 1'b1;

    // request checks and read clamp
    assign past_end  = (op_reg == OP_WRITE) ? (pos_reg > fsize_reg) : (pos_reg >= fsize_reg);
    assign bad_width = (width_reg == '0) || (width_reg > num_servers_reg) ||
                       (width_reg > WID_W'(MAX_SERVERS));
    assign avail       = fsize_reg - pos_reg;
    assign clamp_hit   = (op_reg == OP_READ) &&
                         ({{(POS_W-LEN_W){1'b0}}, bytes_reg} > avail);
    assign bytes_clamp = clamp_hit ? avail[LEN_W-1:0] : bytes_reg;

    // current chunk: up to the next block boundary
    assign room       = CHUNK_W'(BLOCK_BYTES) -
                        {{(CHUNK_W-BLK_LOG2){1'b0}}, pos_reg[BLK_LOG2-1:0]};
    assign len        = (bytes_reg < {{(LEN_W-CHUNK_W){1'b0}}, room}) ?
                        bytes_reg[CHUNK_W-1:0] : room;
    assign chunk_last = (bytes_reg == {{(LEN_W-CHUNK_W){1'b0}}, len}) ||
                        (n_reg == CNT_W'(MAX_CHUNKS - 1));
    assign pos_next   = pos_reg + {{(POS_W-CHUNK_W){1'b0}}, len};
    assign unit_wrap  = (pos_next[UNIT_LOG2-1:0] == '0);
    assign r_inc      = {1'b0, r_reg} + 1'b1;

    // stripe number split by the stripe width
    scm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (pos_reg[POS_W-1:UNIT_LOG2]),
        .divisor   (width_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // status to the controller
    assign sts.reject     = past_end || bad_width;
    assign sts.zero_len   = (bytes_clamp == '0);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.chunk_last = chunk_last;

    // configuration register and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_servers_reg <= WID_W'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                num_servers_reg <= cfg_data;
            end
            if (cmd.emit_status || cmd.emit_chunk) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request registers and chunk walker
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            pos_reg   <= s_start_offset;
            bytes_reg <= s_request_bytes;
            fsize_reg <= s_file_size;
            width_reg <= s_stripe_width;
        end
        if (cmd.check) begin
            bytes_reg       <= bytes_clamp;
            status_code_reg <= past_end ? ST_PAST_EOF : ST_BAD_WIDTH;
            boff_reg        <= '0;
            n_reg           <= '0;
        end
        if (div_done) begin
            q_reg <= div_quo;
            r_reg <= div_rem;
        end
        if (cmd.emit_chunk) begin
            bytes_reg <= bytes_reg - {{(LEN_W-CHUNK_W){1'b0}}, len};
            pos_reg   <= pos_next;
            boff_reg  <= boff_reg + {{(BOFF_W-CHUNK_W){1'b0}}, len};
            n_reg     <= n_reg + 1'b1;
            // crossing into the next stripe unit moves to the next server
            if (unit_wrap) begin
                if (r_inc == width_reg) begin
                    r_reg <= '0;
                    q_reg <= q_reg + 1'b1;
                end else begin
                    r_reg <= r_inc[SRV_W-1:0];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.emit_status) begin
            out_status_reg <= status_code_reg;
            out_server_reg <= '0;
            out_soff_reg   <= '0;
            out_len_reg    <= '0;
            out_boff_reg   <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_chunk) begin
            out_status_reg <= ST_OK;
            out_server_reg <= r_reg;
            out_soff_reg   <= {q_reg, pos_reg[UNIT_LOG2-1:0]};
            out_len_reg    <= len;
            out_boff_reg   <= boff_reg;
            out_last_reg   <= chunk_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_status_reg;
    assign m_server_id     = out_server_reg;
    assign m_server_offset = out_soff_reg;
    assign m_chunk_bytes   = out_len_reg;
    assign m_buffer_offset = out_boff_reg;
    assign m_last          = out_last_reg;

    // checks
    a_emit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_status && cmd.emit_chunk))
        else $error("status and chunk emitted together");

    a_chunk_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_chunk |-> (len != '0))
        else $error("empty chunk emitted");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> ({1'b0, div_rem} < width_reg))
        else $error("server index not below stripe width");

endmodule : scm_dpath

`default_nettype wire

>>> hw/rtl/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl
// Controller: sequences capture, check, stripe division and the emission
// of status or chunk results under output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    output scm_pkg::scm_cmd_t  cmd,
    input  wire scm_pkg::scm_sts_t sts
);
    import scm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_STAT  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (sts.reject) begin
                    state_next = S_STAT;
                end else if (sts.zero_len) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_STAT: begin
                if (sts.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_chunk = 1'b1;
                    if (sts.chunk_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : scm_ctrl

`default_nettype wire

>>> hw/rtl/stripe_chunk_address_mapper_top.sv
// Sequence: a rejected request is checked, then its status result is
// registered once the output is free; a valid request is checked, then
// split by the bit-serial stripe divider, then gives one chunk per cycle
// while the output is free, at most 32 chunks per request. A new request
// is taken only in idle, as there is a single divider and a single walker.
// Reset: synchronous, active low; clears control and sets num_servers to 1.
// ----------------------------------------------------------------------------
// stripe_chunk_address_mapper_top
// Splits a file request into block-bounded chunks striped over servers.
// ----------------------------------------------------------------------------
`default_nettype none

module stripe_chunk_address_mapper_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    // configuration
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [scm_pkg::WID_W-1:0]     cfg_data,
    // request channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_op,
    input  wire [scm_pkg::POS_W-1:0]     s_start_offset,
    input  wire [scm_pkg::LEN_W-1:0]     s_request_bytes,
    input  wire [scm_pkg::POS_W-1:0]     s_file_size,
    input  wire [scm_pkg::WID_W-1:0]     s_stripe_width,
    // result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [scm_pkg::STAT_W-1:0]   m_status,
    output logic [scm_pkg::SRV_W-1:0]    m_server_id,
    output logic [scm_pkg::POS_W-1:0]    m_server_offset,
    output logic [scm_pkg::CHUNK_W-1:0]  m_chunk_bytes,
    output logic [scm_pkg::BOFF_W-1:0]   m_buffer_offset,
    output logic                         m_last
);
    import scm_pkg::*;

    scm_cmd_t cmd;
    scm_sts_t sts;

    // sequencing
    scm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // address arithmetic and result register
    scm_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_op            (s_op),
        .s_start_offset  (s_start_offset),
        .s_request_bytes (s_request_bytes),
        .s_file_size     (s_file_size),
        .s_stripe_width  (s_stripe_width),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_server_id     (m_server_id),
        .m_server_offset (m_server_offset),
        .m_chunk_bytes   (m_chunk_bytes),
        .m_buffer_offset (m_buffer_offset),
        .m_last          (m_last)
    );

endmodule : stripe_chunk_address_mapper_top

`default_nettype wire
